// ----- design/lqm_pkg.sv -----
// shared types and constants for the linked queue manager
package lqm_pkg;

    localparam int NODES   = 16;
    localparam int NODE_W  = 4;
    localparam int COUNT_W = 5;

    localparam logic       CMD_APPEND    = 1'b0;
    localparam logic       CMD_REMOVE    = 1'b1;

    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_QUEUED = 2'd1;
    localparam logic [1:0] STATUS_ABSENT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LINK,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic [NODE_W-1:0]  head;
        logic               empty_res;
    } result_t;

endpackage

// ----- design/linked_queue_manager.sv -----
// top level of the linked queue manager: link memories, sequencer and output register
//
// usage:
//   the input channel (in_valid, in_ready, cmd, node) carries one operation per
//   transaction: cmd 0 appends node at the tail, cmd 1 removes node from anywhere.
//   the output channel (out_valid, out_ready, status, count, head, empty_res)
//   returns exactly one result per operation, in order.
//   in_ready is high only while the sequencer is idle; after the accepting edge it
//   passes through the eval and result states, with a link state between them for an
//   append to a nonempty queue, because the tail splice needs a second write step on
//   the link memories. out_valid is registered from the result state. the sequencer
//   returns to idle as its result is loaded, so it takes no new operation before the
//   last result is loaded; each operation reads the registered link memories first.
//   results wait in an output register; a stalled receiver holds the finished
//   result there, and at most one more operation is processed before the
//   sequencer waits for that register to free up.
//   reset empties the queue and clears all membership bits at once; the link
//   memories need no clearing pass since a link is read only after it is written.
module linked_queue_manager (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic [lqm_pkg::NODE_W-1:0]        node,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [lqm_pkg::COUNT_W-1:0]       count,
    output logic [lqm_pkg::NODE_W-1:0]        head,
    output logic                              empty_res
);

    logic                         res_valid;
    logic                         res_ready;
    lqm_pkg::result_t             res;
    logic                         next_we, prev_we;
    logic [lqm_pkg::NODE_W-1:0]   next_waddr, next_wdata, next_raddr, next_rdata;
    logic [lqm_pkg::NODE_W-1:0]   prev_waddr, prev_wdata, prev_raddr, prev_rdata;
    logic                         out_valid_reg, out_valid_next;
    lqm_pkg::result_t             out_res_reg;

    lqm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .node       (node),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .next_we    (next_we),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata),
        .next_raddr (next_raddr),
        .next_rdata (next_rdata),
        .prev_we    (prev_we),
        .prev_waddr (prev_waddr),
        .prev_wdata (prev_wdata),
        .prev_raddr (prev_raddr),
        .prev_rdata (prev_rdata)
    );

    lqm_ram #(
        .WIDTH (lqm_pkg::NODE_W),
        .DEPTH (lqm_pkg::NODES)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    lqm_ram #(
        .WIDTH (lqm_pkg::NODE_W),
        .DEPTH (lqm_pkg::NODES)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_res_reg.status;
    assign count     = out_res_reg.count;
    assign head      = out_res_reg.head;
    assign empty_res = out_res_reg.empty_res;

endmodule

// ----- design/lqm_ram.sv -----
// generic single write port ram with one registered read port
module lqm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/lqm_seq.sv -----
// sequencer for append and remove over the link memories, with membership and head state
module lqm_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cmd,
    input  logic [lqm_pkg::NODE_W-1:0]     node,
    output logic                           res_valid,
    input  logic                           res_ready,
    output lqm_pkg::result_t               res,
    output logic                           next_we,
    output logic [lqm_pkg::NODE_W-1:0]     next_waddr,
    output logic [lqm_pkg::NODE_W-1:0]     next_wdata,
    output logic [lqm_pkg::NODE_W-1:0]     next_raddr,
    input  logic [lqm_pkg::NODE_W-1:0]     next_rdata,
    output logic                           prev_we,
    output logic [lqm_pkg::NODE_W-1:0]     prev_waddr,
    output logic [lqm_pkg::NODE_W-1:0]     prev_wdata,
    output logic [lqm_pkg::NODE_W-1:0]     prev_raddr,
    input  logic [lqm_pkg::NODE_W-1:0]     prev_rdata
);

    lqm_pkg::state_t                   state_reg, state_next;
    logic                              cmd_reg, cmd_next;
    logic [lqm_pkg::NODE_W-1:0]        node_reg, node_next;
    logic [lqm_pkg::NODE_W-1:0]        head_reg, head_next;
    logic [lqm_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [lqm_pkg::NODES-1:0]         member_reg, member_next;
    logic [1:0]                        status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lqm_pkg::ST_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            member_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            member_reg <= member_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        node_reg   <= node_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        node_next   = node_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        member_next = member_reg;
        status_next = status_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        next_we     = 1'b0;
        next_waddr  = node_reg;
        next_wdata  = node_reg;
        prev_we     = 1'b0;
        prev_waddr  = node_reg;
        prev_wdata  = node_reg;
        // reads are issued while idle so that link data is ready in the eval cycle
        next_raddr  = node;
        prev_raddr  = (cmd == lqm_pkg::CMD_APPEND) ? head_reg : node;

        unique case (state_reg)
            lqm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    node_next  = node;
                    state_next = lqm_pkg::ST_EVAL;
                end
            end
            lqm_pkg::ST_EVAL:
            begin
                state_next  = lqm_pkg::ST_RESULT;
                status_next = lqm_pkg::STATUS_DONE;
                if (cmd_reg == lqm_pkg::CMD_APPEND)
                begin
                    if (member_reg[node_reg])
                    begin
                        status_next = lqm_pkg::STATUS_QUEUED;
                    end
                    else if (count_reg == '0)
                    begin
                        // single node points at itself both ways
                        next_we               = 1'b1;
                        prev_we               = 1'b1;
                        head_next             = node_reg;
                        count_next            = count_reg + 1'b1;
                        member_next[node_reg] = 1'b1;
                    end
                    else
                    begin
                        // prev_rdata holds the tail
                        prev_we    = 1'b1;
                        prev_wdata = prev_rdata;
                        next_we    = 1'b1;
                        next_waddr = prev_rdata;
                        state_next = lqm_pkg::ST_LINK;
                    end
                end
                else
                begin
                    if (!member_reg[node_reg])
                    begin
                        status_next = lqm_pkg::STATUS_ABSENT;
                    end
                    else if (count_reg <= 5'd1)
                    begin
                        head_next             = '0;
                        count_next            = '0;
                        member_next[node_reg] = 1'b0;
                    end
                    else
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = next_rdata;
                        prev_wdata = prev_rdata;
                        next_we    = 1'b1;
                        next_waddr = prev_rdata;
                        next_wdata = next_rdata;
                        if (node_reg == head_reg)
                        begin
                            head_next = next_rdata;
                        end
                        count_next            = count_reg - 1'b1;
                        member_next[node_reg] = 1'b0;
                    end
                end
            end
            lqm_pkg::ST_LINK:
            begin
                // close the ring: new tail points forward to head, head back to new tail
                next_we               = 1'b1;
                next_wdata            = head_reg;
                prev_we               = 1'b1;
                prev_waddr            = head_reg;
                count_next            = count_reg + 1'b1;
                member_next[node_reg] = 1'b1;
                state_next            = lqm_pkg::ST_RESULT;
            end
            lqm_pkg::ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = lqm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lqm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status    = status_reg;
        res.count     = count_reg;
        res.empty_res = (count_reg == '0);
        res.head      = (count_reg == '0) ? '0 : head_reg;
    end

    a_count_matches_members: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(member_reg))
        else $error("queue count differs from number of member bits");

    a_head_is_member: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> member_reg[head_reg])
        else $error("head node of a nonempty queue is not queued");

    a_link_follows_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lqm_pkg::ST_LINK) |-> ($past(state_reg) == lqm_pkg::ST_EVAL
            && cmd_reg == lqm_pkg::CMD_APPEND && !member_reg[node_reg]))
        else $error("tail link step entered outside a valid append");

endmodule
